FILE: hdl/bhq_pkg.sv
`default_nettype none

package bhq_pkg;

  // heap geometry
  localparam int CAPACITY   = 1024;
  localparam int KEY_BITS   = 32;
  localparam int ADDR_BITS  = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int POS_BITS   = COUNT_BITS + 1;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  // operation codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CMP,
    S_DEL_LAST,
    S_DN_RD_L,
    S_DN_RD_R,
    S_DN_SEL,
    S_DN_CMP,
    S_WR_FIN,
    S_DONE
  } state_t;

  // memory request from the sequencer
  typedef struct packed {
    logic  we;
    addr_t waddr;
    key_t  wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  // finished result word
  typedef struct packed {
    key_t    removed;
    status_t status;
    count_t  count;
    key_t    top;
  } result_t;

  // one-based heap position to memory address
  function automatic addr_t pos2addr(input pos_t p);
    pos_t t;
    t = p - pos_t'(1);
    return t[ADDR_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bhq_if.sv
`default_nettype none

// input channel
interface bhq_in_if;
  import bhq_pkg::*;
  logic valid;
  logic ready;
  logic mode;
  key_t item_value;
  modport source (output valid, mode, item_value, input ready);
  modport sink   (input valid, mode, item_value, output ready);
endinterface

// result channel
interface bhq_out_if;
  import bhq_pkg::*;
  logic    valid;
  logic    ready;
  key_t    removed_value;
  status_t status;
  count_t  entry_count;
  key_t    top_value;
  modport source (output valid, removed_value, status, entry_count, top_value, input ready);
  modport sink   (input valid, removed_value, status, entry_count, top_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/binary_max_heap_queue_unit.sv
// Max priority queue of 32-bit unsigned keys held as a binary heap in a
// 1024-entry memory with one write and one registered read port.
// in_if carries mode (0 insert, 1 delete max) and item_value; out_if
// returns one word per item: removed_value, status, entry_count, top_value.
// Both channels move a word when valid and ready are high at a clock edge.
// One item is worked at a time; in_if.ready is high only while idle.
// Insert swims the key up one level a cycle. Delete sinks the moved entry
// level by level (read, child select, compare and move) through the single
// comparator. Empty-delete and full-insert go straight to the result.
// The result sits in an output register, so the next item is taken while
// it waits; a further result waits in the sequencer until the register
// frees, and no input is taken meanwhile.
// Synchronous active-low reset empties the queue; memory contents are not
// cleared, since only positions up to the count are ever read.
`default_nettype none

module binary_max_heap_queue_unit (
  input wire logic  clk,
  input wire logic  rst_n,
  bhq_in_if.sink    in_if,
  bhq_out_if.source out_if
);

  import bhq_pkg::*;

  ram_req_t ram_req;
  key_t     ram_rdata;
  result_t  res;
  logic     res_load;
  logic     res_free;
  logic     out_valid_r;
  result_t  out_word_r;

  assign res_free = !out_valid_r || out_if.ready;

  bhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_mode   (in_if.mode),
    .in_key    (in_if.item_value),
    .in_ready  (in_if.ready),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  bhq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // output word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_word_r <= res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.removed_value = out_word_r.removed;
  assign out_if.status        = out_word_r.status;
  assign out_if.entry_count   = out_word_r.count;
  assign out_if.top_value     = out_word_r.top;

endmodule

`default_nettype wire

FILE: hdl/bhq_ram.sv
`default_nettype none

module bhq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bhq_ctrl.sv
`default_nettype none

module bhq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_mode,
  input  wire bhq_pkg::key_t     in_key,
  output logic                   in_ready,
  input  wire logic              res_free,
  output logic                   res_load,
  output bhq_pkg::result_t       res,
  output bhq_pkg::ram_req_t      ram_req,
  input  wire bhq_pkg::key_t     ram_rdata
);

  import bhq_pkg::*;

  state_t  state_r, state_nxt;
  count_t  count_r, count_nxt;
  pos_t    pos_r, pos_nxt;
  pos_t    child_r, child_nxt;
  key_t    key_r, key_nxt;
  key_t    lval_r, lval_nxt;
  key_t    cval_r, cval_nxt;
  key_t    top_r, top_nxt;
  key_t    removed_r, removed_nxt;
  status_t status_r, status_nxt;

  // shared compare unit
  key_t cmp_a, cmp_b;
  logic cmp_lt;
  assign cmp_lt = cmp_a < cmp_b;

  pos_t new_pos, half_pos, dbl_pos, dbl_child, count_ext;
  assign new_pos   = pos_t'(count_r) + pos_t'(1);
  assign half_pos  = pos_r >> 1;
  assign dbl_pos   = pos_r << 1;
  assign dbl_child = child_r << 1;
  assign count_ext = pos_t'(count_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    child_r   <= child_nxt;
    key_r     <= key_nxt;
    lval_r    <= lval_nxt;
    cval_r    <= cval_nxt;
    top_r     <= top_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    child_nxt   = child_r;
    key_nxt     = key_r;
    lval_nxt    = lval_r;
    cval_nxt    = cval_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    in_ready    = 1'b0;
    res_load    = 1'b0;
    cmp_a       = ram_rdata;
    cmp_b       = key_r;
    ram_req     = '0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          removed_nxt = '0;
          status_nxt  = STATUS_OK;
          if (in_mode == MODE_INSERT) begin
            if (count_ext == pos_t'(CAPACITY)) begin
              status_nxt = STATUS_FULL;
              state_nxt  = S_DONE;
            end else begin
              count_nxt = count_r + count_t'(1);
              pos_nxt   = new_pos;
              key_nxt   = in_key;
              if (count_r == '0) begin
                state_nxt = S_WR_FIN;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = pos2addr(new_pos >> 1);
                state_nxt     = S_UP_CMP;
              end
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = STATUS_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              removed_nxt   = top_r;
              ram_req.re    = 1'b1;
              ram_req.raddr = pos2addr(count_ext);
              state_nxt     = S_DEL_LAST;
            end
          end
        end
      end

      // swim: parent smaller than the key moves down into the hole
      S_UP_CMP: begin
        cmp_a = ram_rdata;
        cmp_b = key_r;
        if (cmp_lt) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pos2addr(pos_r);
          ram_req.wdata = ram_rdata;
          pos_nxt       = half_pos;
          if (half_pos == pos_t'(1)) begin
            state_nxt = S_WR_FIN;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = pos2addr(half_pos >> 1);
          end
        end else begin
          state_nxt = S_WR_FIN;
        end
      end

      // last entry becomes the key to sink from the root
      S_DEL_LAST: begin
        key_nxt   = ram_rdata;
        count_nxt = count_r - count_t'(1);
        pos_nxt   = pos_t'(1);
        if (count_r == count_t'(1)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DN_RD_L;
        end
      end

      S_DN_RD_L: begin
        if (dbl_pos > count_ext) begin
          state_nxt = S_WR_FIN;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = pos2addr(dbl_pos);
          child_nxt     = dbl_pos;
          state_nxt     = S_DN_RD_R;
        end
      end

      // left child arrives, fetch right child if present
      S_DN_RD_R: begin
        lval_nxt = ram_rdata;
        if (child_r < count_ext) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = pos2addr(child_r + pos_t'(1));
          state_nxt     = S_DN_SEL;
        end else begin
          cval_nxt  = ram_rdata;
          state_nxt = S_DN_CMP;
        end
      end

      // pick the larger child, left on a tie
      S_DN_SEL: begin
        cmp_a = lval_r;
        cmp_b = ram_rdata;
        if (cmp_lt) begin
          cval_nxt  = ram_rdata;
          child_nxt = child_r + pos_t'(1);
        end else begin
          cval_nxt  = lval_r;
        end
        state_nxt = S_DN_CMP;
      end

      // larger child moves up into the hole, next left child read early
      S_DN_CMP: begin
        cmp_a = key_r;
        cmp_b = cval_r;
        if (cmp_lt) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pos2addr(pos_r);
          ram_req.wdata = cval_r;
          pos_nxt       = child_r;
          if (dbl_child > count_ext) begin
            state_nxt = S_WR_FIN;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = pos2addr(dbl_child);
            child_nxt     = dbl_child;
            state_nxt     = S_DN_RD_R;
          end
        end else begin
          state_nxt = S_WR_FIN;
        end
      end

      S_WR_FIN: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos2addr(pos_r);
        ram_req.wdata = key_r;
        state_nxt     = S_DONE;
      end

      S_DONE: begin
        if (res_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // root copy follows every write to the root
  always_comb begin
    top_nxt = top_r;
    if (ram_req.we && ram_req.waddr == '0) begin
      top_nxt = ram_req.wdata;
    end
  end

  // result word
  always_comb begin
    res.removed = removed_r;
    res.status  = status_r;
    res.count   = count_r;
    res.top     = (count_r == '0) ? '0 : top_r;
  end

endmodule

`default_nettype wire

FILE: hdl/bhq_chk.sv
`default_nettype none

module bhq_chk (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic [1:0]      out_status,
  input wire bhq_pkg::count_t out_count
);

  import bhq_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_count))
    else $error("result word changed while stalled");

  // an accepted item keeps the block busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // empty-delete reports an empty queue
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_EMPTY |-> out_count == '0)
    else $error("empty status with nonzero count");

  // count stays within capacity and status is a known code
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= count_t'(CAPACITY) &&
                  (out_status == STATUS_OK || out_status == STATUS_EMPTY ||
                   out_status == STATUS_FULL))
    else $error("result count or status out of range");

  // full-insert only when at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FULL |-> out_count == count_t'(CAPACITY))
    else $error("full status below capacity");

endmodule

bind binary_max_heap_queue_unit bhq_chk u_bhq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_status (out_if.status),
  .out_count  (out_if.entry_count)
);

`default_nettype wire

FILE: bench/binary_max_heap_queue_unit_tb.sv
`timescale 1ns / 100ps

module binary_max_heap_queue_unit_tb;
  import bhq_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int TAIL_CYCLES  = 40;
  localparam int HOLD_CYCLES  = 500;
  localparam int HOLD_AFTER   = 350;

  // receiver stall styles
  localparam int RX_STEADY = 0;
  localparam int RX_HALF   = 1;
  localparam int RX_SPARSE = 2;

  // heap predictor and expected result words
  class heap_scoreboard;
    key_t        heap_keys [1:CAPACITY];
    int unsigned held;
    result_t     pending [$];
    int unsigned failures;
    int unsigned results_seen;
    int unsigned inserts, deletes, full_rejects, empty_deletes, peak;

    // predict the result word for one accepted input word
    function void note_item(input logic m, input key_t v);
      result_t     exp_word;
      int unsigned p, c;
      key_t        t;
      logic        moving;
      exp_word.removed = '0;
      exp_word.status  = STATUS_OK;
      if (m == MODE_INSERT) begin
        inserts++;
        if (held >= CAPACITY) begin
          exp_word.status = STATUS_FULL;
          full_rejects++;
        end else begin
          // append and swim up while the parent is smaller
          held++;
          heap_keys[held] = v;
          p = held;
          while (p > 1 && heap_keys[p / 2] < heap_keys[p]) begin
            t = heap_keys[p / 2];
            heap_keys[p / 2] = heap_keys[p];
            heap_keys[p] = t;
            p = p / 2;
          end
        end
      end else begin
        deletes++;
        if (held == 0) begin
          exp_word.status = STATUS_EMPTY;
          empty_deletes++;
        end else begin
          // take the root, move the last entry up and sink it
          exp_word.removed = heap_keys[1];
          heap_keys[1] = heap_keys[held];
          held--;
          p = 1;
          moving = 1'b1;
          while (moving && 2 * p <= held) begin
            c = 2 * p;
            if (c < held && heap_keys[c] < heap_keys[c + 1]) c++;
            if (heap_keys[p] < heap_keys[c]) begin
              t = heap_keys[p];
              heap_keys[p] = heap_keys[c];
              heap_keys[c] = t;
              p = c;
            end else begin
              moving = 1'b0;
            end
          end
        end
      end
      if (held > peak) peak = held;
      exp_word.count = count_t'(held);
      exp_word.top   = (held != 0) ? heap_keys[1] : '0;
      pending.push_back(exp_word);
    endfunction

    // compare one accepted result word with the oldest prediction
    function void check_word(input key_t removed, input status_t st, input count_t cnt,
                             input key_t top);
      result_t exp_word;
      results_seen++;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result word: removed=%h status=%0d count=%0d top=%h",
                   removed, st, cnt, top);
        return;
      end
      exp_word = pending.pop_front();
      if (removed !== exp_word.removed || st !== exp_word.status ||
          cnt !== exp_word.count || top !== exp_word.top) begin
        failures++;
        if (failures <= 10)
          $display({"result %0d mismatch: exp removed=%h status=%0d count=%0d top=%h,",
                    " got removed=%h status=%0d count=%0d top=%h"},
                   results_seen, exp_word.removed, exp_word.status, exp_word.count,
                   exp_word.top, removed, st, cnt, top);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bhq_in_if  in_if ();
  bhq_out_if out_if ();

  binary_max_heap_queue_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  heap_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  logic        stim_done = 1'b0;
  logic        receiver_hold = 1'b0;
  int          rx_style = RX_STEADY;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // keys biased toward duplicates and both ends of the range
  function automatic key_t draw_key();
    case ($urandom_range(0, 3))
      0: return key_t'($urandom_range(0, 15));
      1: return key_t'('1) - key_t'($urandom_range(0, 15));
      default: return key_t'($urandom());
    endcase
  endfunction

  // offer one word, with bursts and random gaps between them
  task automatic offer_word(input logic m, input key_t v);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= m;
    in_if.item_value <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_item(m, v);
    burst_left--;
  endtask

  // random words, delete_pct percent of them deletes
  task automatic offer_mix(input int unsigned n, input int unsigned delete_pct);
    int unsigned i;
    for (i = 0; i < n; i++)
      offer_word(($urandom_range(0, 99) < delete_pct) ? MODE_DELETE : MODE_INSERT, draw_key());
  endtask

  // result side: check accepted words and stall on a pattern
  initial begin
    logic go;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_if.valid && out_if.ready) begin
        sb.check_word(out_if.removed_value, out_if.status, out_if.entry_count,
                      out_if.top_value);
        if (sb.results_seen % 60 == 0) rx_style = $urandom_range(RX_STEADY, RX_SPARSE);
      end
      if (stim_done) go = 1'b1;
      else if (receiver_hold) go = 1'b0;
      else begin
        case (rx_style)
          RX_STEADY: go = 1'b1;
          RX_HALF:   go = ($urandom_range(0, 1) == 1);
          default:   go = ($urandom_range(0, 4) == 0);
        endcase
      end
      out_if.ready <= go;
      @(posedge clk);
    end
  end

  // long hold-off on the result side so the input backs up
  initial begin
    @(posedge clk);
    while (sb.results_seen < HOLD_AFTER) @(posedge clk);
    receiver_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold = 1'b0;
  end

  // watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             sb.pending.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // reset, stimulus and final report
  initial begin
    in_if.valid      <= 1'b0;
    in_if.mode       <= MODE_INSERT;
    in_if.item_value <= '0;
    rst_n            <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // delete on empty, key extremes, equal keys
    offer_word(MODE_DELETE, 32'h1234_5678);
    offer_word(MODE_INSERT, 32'h0000_0000);
    offer_word(MODE_INSERT, 32'hFFFF_FFFF);
    offer_word(MODE_INSERT, 32'h8000_0000);
    offer_word(MODE_INSERT, 32'h7FFF_FFFF);
    offer_word(MODE_INSERT, 32'h0000_0005);
    offer_word(MODE_INSERT, 32'h0000_0005);
    offer_word(MODE_INSERT, 32'hFFFF_FFFF);
    offer_word(MODE_INSERT, 32'h0000_0000);
    repeat (8) offer_word(MODE_DELETE, 32'hA5A5_A5A5);
    offer_word(MODE_DELETE, 32'h5A5A_5A5A);
    // equal children on the sink path, left one wins
    offer_word(MODE_INSERT, 32'd10);
    offer_word(MODE_INSERT, 32'd7);
    offer_word(MODE_INSERT, 32'd7);
    offer_word(MODE_INSERT, 32'd3);
    repeat (2) offer_word(MODE_DELETE, '0);

    // random mix at low fill
    offer_mix(300, 40);
    // fill to capacity, then insert on full
    while (sb.held < CAPACITY)
      offer_word(($urandom_range(0, 29) == 0) ? MODE_DELETE : MODE_INSERT, draw_key());
    repeat (6) offer_word(MODE_INSERT, draw_key());
    // churn near full, then drain part of it
    offer_mix(40, 50);
    offer_mix(450, 80);

    in_if.valid <= 1'b0;
    stim_done = 1'b1;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d inserts (%0d rejected as full) and %0d deletes (%0d on empty)",
             sb.inserts, sb.full_rejects, sb.deletes, sb.empty_deletes);
    $display("peak fill %0d of %0d, %0d result words checked, %0d failures",
             sb.peak, CAPACITY, sb.results_seen, sb.failures);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
